FILE: design/cis_pkg.sv
// Shared types, constants and helpers for the case-insensitive substring search unit.
package cis_pkg;

	// Storage and field widths
	localparam int MAX_NEEDLE_DEF = 31;
	localparam int NDL_BYTES      = 31;
	localparam int NDL_BITS       = NDL_BYTES * 8;
	localparam int LEN_W          = 5;
	localparam int POS_W          = 32;
	localparam int CFG_W          = 64;
	localparam int IDX_W          = 3;

	// ASCII letters used by case folding
	localparam logic [7:0] CHAR_UP_A = 8'h41;
	localparam logic [7:0] CHAR_UP_Z = 8'h5A;
	localparam logic [7:0] CHAR_LO_A = 8'h61;

	// Configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		CFG_PAT0   = 3'd0,
		CFG_PAT1   = 3'd1,
		CFG_PAT2   = 3'd2,
		CFG_PAT3   = 3'd3,
		CFG_LEN    = 3'd4,
		CFG_OFFSET = 3'd5
	} cfg_idx_t;

	// One search result
	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] pos;
	} res_t;

	// Per-cell compare control
	typedef struct packed {
		logic       en;
		logic [7:0] needle;
	} cell_ctl_t;

	// Fold ASCII upper case to lower case, other bytes pass unchanged
	function automatic logic [7:0] fold(input logic [7:0] x);
		logic [7:0] r;
		r = x;
		if (x >= CHAR_UP_A && x <= CHAR_UP_Z) begin
			r = x - CHAR_UP_A + CHAR_LO_A;
		end
		return r;
	endfunction

	// Select needle byte idx; out-of-range slots read as zero
	function automatic logic [7:0] pick_byte(input logic [NDL_BITS-1:0] v,
			input logic [LEN_W-1:0] idx);
		logic [7:0] r;
		r = '0;
		for (int j = 0; j < NDL_BYTES; j++) begin
			if (idx == LEN_W'(j)) begin
				r = v[j*8 +: 8];
			end
		end
		return r;
	endfunction

endpackage

FILE: design/cis_cell.sv
// One history cell: holds a folded text byte, passes it on and compares its new byte.
module cis_cell (
	input  logic               clk,
	input  logic               shift,
	input  logic [7:0]         d_in,
	input  cis_pkg::cell_ctl_t ctl,
	output logic [7:0]         hist_q,
	output logic               hit
);
	import cis_pkg::*;

	// History byte moves one cell down on every accepted byte
	always_ff @(posedge clk) begin
		if (shift) begin
			hist_q <= d_in;
		end
	end

	// Disabled cells always agree
	assign hit = !ctl.en || (d_in == fold(ctl.needle));

endmodule

FILE: design/cis_obuf.sv
// Two-entry result buffer: output register plus skid slot.
module cis_obuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cis_pkg::res_t push_data,
	output logic          full,
	output logic          out_valid,
	input  logic          out_stall,
	output cis_pkg::res_t out_data
);
	import cis_pkg::*;

	logic v0_q, v1_q;
	res_t d0_q, d1_q;
	logic pop;

	assign pop       = v0_q && !out_stall;
	assign full      = v1_q;
	assign out_valid = v0_q;
	assign out_data  = d0_q;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else if (pop) begin
			if (v1_q) begin
				v1_q <= push;
			end else begin
				v0_q <= push;
			end
		end else if (push) begin
			if (v0_q) begin
				v1_q <= 1'b1;
			end else begin
				v0_q <= 1'b1;
			end
		end
	end

	// Payload slots
	always_ff @(posedge clk) begin
		if (pop) begin
			if (v1_q) begin
				d0_q <= d1_q;
				if (push) begin
					d1_q <= push_data;
				end
			end else if (push) begin
				d0_q <= push_data;
			end
		end else if (push) begin
			if (v0_q) begin
				d1_q <= push_data;
			end else begin
				d0_q <= push_data;
			end
		end
	end

endmodule

FILE: design/case_insensitive_substring_search_unit.sv
// Top level of the ASCII case-insensitive substring search unit.
// Streams text one byte per transfer and reports the first place where the
// configured needle (up to 31 bytes, A-Z folded to lower case on both sides)
// matches: one result per text, either found with the start position, on the
// byte that completes the match, or not found on the byte flagged last.
// Throughput is one byte per clock while not stalled: a row of MAX_NEEDLE
// history cells shifts and compares in parallel in the cycle the byte is taken,
// and the result is registered into a two-entry output buffer. The input
// stalls only while both buffer entries are held. Configuration writes are
// always accepted (cfg_ready is tied high) and must be made while idle;
// writing the first-byte position register also resets the running position.
module case_insensitive_substring_search_unit #(
	parameter int MAX_NEEDLE = cis_pkg::MAX_NEEDLE_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// text input
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [7:0]               text_byte,
	input  logic                     is_last,
	// result output
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     found,
	output logic [cis_pkg::POS_W-1:0] match_position,
	// configuration write
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [cis_pkg::IDX_W-1:0] cfg_index,
	input  logic [cis_pkg::CFG_W-1:0] cfg_data
);
	import cis_pkg::*;

	localparam int SEEN_W = $clog2(MAX_NEEDLE + 1);

	logic [NDL_BITS-1:0] needle_q;
	logic [LEN_W-1:0]    len_q;
	logic [POS_W-1:0]    offset_q;
	logic [POS_W-1:0]    pos_q;
	logic [SEEN_W-1:0]   seen_q;
	logic                done_q;

	logic                accept;
	logic                cfg_wr;
	logic [LEN_W-1:0]    len_eff;
	logic [SEEN_W-1:0]   seen_nxt;
	logic                seen_ok;
	logic                match;
	logic                push;
	logic                full;
	res_t                push_data;
	res_t                out_data;

	logic [7:0]          din  [MAX_NEEDLE];
	logic [7:0]          hist [MAX_NEEDLE];
	cell_ctl_t           ctl  [MAX_NEEDLE];
	logic [MAX_NEEDLE-1:0] hit;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign in_stall  = full;
	assign accept    = in_valid && !in_stall;

	// Needle length limited to the cell count
	assign len_eff = (int'(len_q) > MAX_NEEDLE) ? LEN_W'(MAX_NEEDLE) : len_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_q <= '0;
			len_q    <= '0;
			offset_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				CFG_PAT0:   needle_q[63:0]    <= cfg_data;
				CFG_PAT1:   needle_q[127:64]  <= cfg_data;
				CFG_PAT2:   needle_q[191:128] <= cfg_data;
				CFG_PAT3:   needle_q[NDL_BITS-1:192] <= cfg_data[NDL_BITS-193:0];
				CFG_LEN:    len_q    <= cfg_data[LEN_W-1:0];
				CFG_OFFSET: offset_q <= cfg_data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	// Cell row
	for (genvar k = 0; k < MAX_NEEDLE; k++) begin : g_cell
		logic [LEN_W-1:0] nidx;

		if (k == 0) begin : g_head
			assign din[k] = fold(text_byte);
		end else begin : g_body
			assign din[k] = hist[k-1];
		end

		// Cell k holds the byte that lines up with needle byte len-1-k
		assign nidx       = len_eff - LEN_W'(k + 1);
		assign ctl[k].en  = k < int'(len_eff);
		assign ctl[k].needle = pick_byte(needle_q, nidx);

		cis_cell u_cell (
			.clk    (clk),
			.shift  (accept),
			.d_in   (din[k]),
			.ctl    (ctl[k]),
			.hist_q (hist[k]),
			.hit    (hit[k])
		);
	end

	// Match decision on the byte being taken
	assign seen_nxt = (seen_q == SEEN_W'(MAX_NEEDLE)) ? seen_q : seen_q + SEEN_W'(1);
	assign seen_ok  = int'(seen_nxt) >= int'(len_eff);
	assign match    = !done_q && (len_eff != '0) && seen_ok && (&hit);

	// Result: found at the first match, not found at the end otherwise
	assign push           = accept && (match || (is_last && !done_q));
	assign push_data.found = match;
	assign push_data.pos  = match ? (pos_q - POS_W'(len_eff) + POS_W'(1)) : '0;

	// Per-text search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			seen_q <= '0;
			done_q <= 1'b0;
		end else if (accept) begin
			if (is_last) begin
				pos_q  <= offset_q;
				seen_q <= '0;
				done_q <= 1'b0;
			end else begin
				pos_q  <= pos_q + POS_W'(1);
				seen_q <= seen_nxt;
				done_q <= done_q || match;
			end
		end else if (cfg_wr && cfg_index == CFG_OFFSET) begin
			pos_q <= cfg_data[POS_W-1:0];
		end
	end

	cis_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign found          = out_data.found;
	assign match_position = out_data.pos;

endmodule

FILE: design/cis_chk.sv
// Port-level checker for the search unit, bound to the top level.
module cis_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        found,
	input logic [31:0] match_position
);

	// A held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// Not-found results carry position zero
	a_nf_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_position == 32'd0)
		else $error("not-found result with nonzero position");

	// A new result needs a byte transfer in the cycle before
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall))
		else $error("result without a byte transfer");

	// Input stalls only while results are waiting
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no pending result");

endmodule

bind case_insensitive_substring_search_unit cis_chk u_cis_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.found          (found),
	.match_position (match_position)
);

FILE: dv/case_insensitive_substring_search_unit_tb.sv
// Self-checking testbench for the case-insensitive substring search unit.
module case_insensitive_substring_search_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cis_pkg::*;

	// Unused register slots, writes there must be ignored
	localparam logic [IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [IDX_W-1:0] CFG_SPARE_HI = 3'd7;
	localparam logic [7:0]       CASE_BIT     = 8'h20;
	localparam logic [7:0]       CHAR_LO_Z    = CHAR_LO_A + 8'd25;
	localparam int               TEXT_TARGET  = 1950;
	localparam int               HOLD_CYCLES  = 120;

	// Tracks the expected search results for the streamed text
	class match_tracker;
		logic [63:0]      pat_w[4];
		logic [LEN_W-1:0] pat_len;
		logic [POS_W-1:0] base_pos;
		logic [7:0]       hist[NDL_BYTES];
		int               seen;
		logic [POS_W-1:0] next_pos;
		bit               done;
		res_t             pending_matches[$];
		int               errors;

		function new();
			foreach (pat_w[k]) pat_w[k] = '0;
			pat_len  = '0;
			base_pos = '0;
			errors   = 0;
			rearm();
		endfunction

		// State for the start of a new text
		function void rearm();
			foreach (hist[k]) hist[k] = '0;
			seen     = 0;
			next_pos = base_pos;
			done     = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] d);
			case (idx)
				CFG_PAT0: pat_w[0] = d;
				CFG_PAT1: pat_w[1] = d;
				CFG_PAT2: pat_w[2] = d;
				CFG_PAT3: pat_w[3] = {8'h00, d[55:0]};
				CFG_LEN: pat_len = d[LEN_W-1:0];
				CFG_OFFSET: begin
					base_pos = d[POS_W-1:0];
					next_pos = base_pos;
				end
				default: ;
			endcase
		endfunction

		function logic [7:0] to_lower(logic [7:0] b);
			if (b >= CHAR_UP_A && b <= CHAR_UP_Z) return b | CASE_BIT;
			return b;
		endfunction

		// Shift in one accepted byte and work out the result it causes
		function void take_byte(logic [7:0] b, logic last);
			logic [POS_W-1:0] at;
			int               len;
			bit               hit;
			res_t             r;
			at  = next_pos;
			len = int'(pat_len);
			for (int i = NDL_BYTES - 1; i > 0; i--) hist[i] = hist[i-1];
			hist[0] = b;
			if (seen < NDL_BYTES) seen++;
			next_pos = at + 1;
			if (!done && len > 0 && seen >= len) begin
				hit = 1;
				for (int j = 0; j < len; j++) begin
					if (to_lower(hist[len-1-j]) != to_lower(pat_w[j/8][(j%8)*8 +: 8]))
						hit = 0;
				end
				if (hit) begin
					done    = 1;
					r.found = 1'b1;
					r.pos   = at - POS_W'(len - 1);
					pending_matches.push_back(r);
				end
			end
			if (last) begin
				if (!done) begin
					r.found = 1'b0;
					r.pos   = '0;
					pending_matches.push_back(r);
				end
				rearm();
			end
		endfunction

		// Compare one delivered result with the oldest expectation
		function void check_match(logic f, logic [POS_W-1:0] p);
			res_t e;
			if (pending_matches.size() == 0) begin
				errors++;
				$display("%0t: unexpected result found=%0b pos=%h", $realtime, f, p);
				return;
			end
			e = pending_matches.pop_front();
			if (f !== e.found) begin
				errors++;
				$display("%0t: found expected %0b actual %0b", $realtime, e.found, f);
			end
			if (p !== e.pos) begin
				errors++;
				$display("%0t: match_position expected %h actual %h", $realtime, e.pos, p);
			end
		endfunction

		function int outstanding();
			return pending_matches.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [7:0]       text_byte;
	logic             is_last;
	logic             out_valid;
	logic             out_stall;
	logic             found;
	logic [POS_W-1:0] match_position;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	match_tracker tracker = new();

	// Needle as programmed, used only to shape the text
	logic [63:0]      stim_w[4];
	logic [LEN_W-1:0] stim_len;
	bit               calm;
	bit               long_hold_req;
	int               bytes_sent;

	case_insensitive_substring_search_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.text_byte      (text_byte),
		.is_last        (is_last),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.found          (found),
		.match_position (match_position),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Hard limit on run time
	initial begin : watchdog
		#1_000_000;
		$display("[case_insensitive_substring_search_unit] ERROR");
		$finish;
	end

	// Result side: check transfers, stall at random or for a long hold
	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) tracker.check_match(found, match_position);
			if (long_hold_req) begin
				long_hold_req = 0;
				hold_left     = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (calm) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < 37);
			end
		end
	end

	function automatic logic [7:0] stim_needle(int k);
		return stim_w[k/8][(k%8)*8 +: 8];
	endfunction

	function automatic bit is_letter(logic [7:0] b);
		return (b >= CHAR_UP_A && b <= CHAR_UP_Z) || (b >= CHAR_LO_A && b <= CHAR_LO_Z);
	endfunction

	function automatic logic [7:0] maybe_swap_case(logic [7:0] b);
		if (is_letter(b) && $urandom_range(0, 1)) return b ^ CASE_BIT;
		return b;
	endfunction

	// Bytes around the edges of the folded range
	function automatic logic [7:0] edge_char();
		case ($urandom_range(0, 5))
			0: return CHAR_UP_A - 8'd1;
			1: return CHAR_UP_Z + 8'd1;
			2: return CHAR_LO_A - 8'd1;
			3: return CHAR_LO_Z + 8'd1;
			4: return CHAR_UP_Z;
			default: return CHAR_LO_A;
		endcase
	endfunction

	function automatic logic [7:0] needle_char();
		case ($urandom_range(0, 3))
			0: return CHAR_LO_A + 8'($urandom_range(0, 25));
			1: return CHAR_UP_A + 8'($urandom_range(0, 25));
			2: return edge_char();
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Filler text, often close to the needle
	function automatic logic [7:0] noise_char();
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(0, 255));
			1: return maybe_swap_case(stim_needle($urandom_range(0,
				(stim_len == 0) ? 0 : int'(stim_len) - 1)));
			2: return edge_char();
			default: return CHAR_LO_A + 8'($urandom_range(0, 25));
		endcase
	endfunction

	// One register write transfer; cfg_valid is lowered by cfg_close
	task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tracker.write_reg(idx, d);
		case (idx)
			CFG_PAT0: stim_w[0] = d;
			CFG_PAT1: stim_w[1] = d;
			CFG_PAT2: stim_w[2] = d;
			CFG_PAT3: stim_w[3] = {8'h00, d[55:0]};
			CFG_LEN: stim_len = d[LEN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic cfg_close();
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// One text byte transfer, with a random idle gap in front
	task automatic send_byte(input logic [7:0] b, input logic last);
		while (!calm && $urandom_range(0, 99) < 37) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		text_byte <= b;
		is_last   <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tracker.take_byte(b, last);
		bytes_sent++;
	endtask

	// Stop sending and wait until every result has come out
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Random text: mostly the needle in random case inside filler
	task automatic send_text(input bit finish);
		logic [7:0] body[$];
		int         kind;
		int         len;
		int         idx;
		kind = $urandom_range(0, 9);
		len  = int'(stim_len);
		repeat ($urandom_range(0, 12)) body.push_back(noise_char());
		if (kind < 6) begin
			for (int j = 0; j < len; j++) body.push_back(maybe_swap_case(stim_needle(j)));
			if (len > 0 && $urandom_range(0, 3) == 0) begin
				idx       = body.size() - 1 - $urandom_range(0, len - 1);
				body[idx] = body[idx] ^ (8'h01 << $urandom_range(0, 7));
			end
		end else if (kind < 8) begin
			if (len > 1) begin
				for (int j = 0; j < $urandom_range(1, len - 1); j++)
					body.push_back(maybe_swap_case(stim_needle(j)));
			end
		end else begin
			repeat ($urandom_range(0, 20)) body.push_back(8'($urandom_range(0, 255)));
		end
		repeat ($urandom_range(0, 6)) body.push_back(noise_char());
		if ($urandom_range(0, 24) == 0)
			repeat ($urandom_range(60, 120)) body.push_back(noise_char());
		if (body.size() == 0) body.push_back(noise_char());
		foreach (body[k]) send_byte(body[k], finish && (k == body.size() - 1));
	endtask

	// Random register settings for one phase, extremes included
	task automatic program_regs(input int phase);
		logic [CFG_W-1:0] w;
		int               pick;
		int               len;
		for (int k = 0; k < 4; k++) begin
			if (phase == 0 || $urandom_range(0, 3) != 0) begin
				pick = $urandom_range(0, 9);
				if (pick == 0) w = '1;
				else if (pick == 1) w = '0;
				else for (int b = 0; b < 8; b++) w[b*8 +: 8] = needle_char();
				if (k == 3) w[63:56] = 8'($urandom_range(0, 255));
				cfg_write(cfg_idx_t'(k), w);
			end
		end
		if (phase <= 1 || $urandom_range(0, 3) != 0) begin
			pick = $urandom_range(0, 19);
			if (phase == 1 || pick == 1) len = NDL_BYTES;
			else if (pick == 0) len = 0;
			else if (pick == 2) len = 1;
			else if (pick < 5) len = $urandom_range(9, 30);
			else len = $urandom_range(2, 8);
			w = {$urandom, $urandom};
			w[LEN_W-1:0] = LEN_W'(len);
			cfg_write(CFG_LEN, w);
		end
		if (phase == 0 || $urandom_range(0, 2) != 0) begin
			w = {$urandom, $urandom};
			case ($urandom_range(0, 7))
				0: w[31:0] = '0;
				1: w[31:0] = '1;
				2: w[31:0] = 32'hFFFF_FFFF - 32'($urandom_range(0, 40));
				default: ;
			endcase
			cfg_write(CFG_OFFSET, w);
		end
		if ($urandom_range(0, 3) == 0)
			cfg_write($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, {$urandom, $urandom});
		cfg_close();
	endtask

	initial begin : stimulus
		int phase;
		int n_texts;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		text_byte     = '0;
		is_last       = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		calm          = 0;
		long_hold_req = 0;
		bytes_sent    = 0;
		foreach (stim_w[k]) stim_w[k] = '0;
		stim_len = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Needle "aB[" from position 5, spare slots written as well
		cfg_write(CFG_PAT0, 64'h0000_0000_005B_4261);
		cfg_write(CFG_PAT1, '0);
		cfg_write(CFG_PAT2, '0);
		cfg_write(CFG_PAT3, '1);
		cfg_write(CFG_LEN, 64'd3);
		cfg_write(CFG_OFFSET, 64'd5);
		cfg_write(CFG_SPARE_LO, '1);
		cfg_write(CFG_SPARE_HI, '1);
		cfg_close();
		// Mixed-case match, then bytes after the match up to the end
		send_byte(8'h58, 0); send_byte(8'h41, 0); send_byte(8'h62, 0);
		send_byte(8'h5B, 0); send_byte(8'h7A, 0); send_byte(8'hFF, 1);
		// '{' must not fold onto '[': not found
		send_byte(8'h61, 0); send_byte(8'h62, 0); send_byte(8'h7B, 1);
		// Match completed by the last byte
		send_byte(8'h41, 0); send_byte(8'h42, 0); send_byte(8'h5B, 1);
		settle();
		// Empty needle never matches
		cfg_write(CFG_LEN, 64'd0);
		cfg_close();
		send_byte(8'h00, 0); send_byte(8'hFF, 1);
		settle();
		// Position wraps past the top of the range
		cfg_write(CFG_PAT0, '1);
		cfg_write(CFG_LEN, 64'd2);
		cfg_write(CFG_OFFSET, 64'hFFFF_FFFF);
		cfg_close();
		send_byte(8'h00, 0); send_byte(8'hFF, 0); send_byte(8'hFF, 1);
		// Offset write in the middle of a text reloads the position
		send_byte(8'h11, 0);
		settle();
		cfg_write(CFG_OFFSET, 64'hFFFF_FFFE);
		cfg_close();
		send_byte(8'hFF, 0); send_byte(8'hFF, 1);
		settle();

		// Random phases, register settings change between them
		phase = 0;
		while (bytes_sent < TEXT_TARGET) begin
			program_regs(phase);
			calm = (phase % 10 == 4);
			if (phase == 2) begin
				// Results pile up behind a long hold until the input stalls
				long_hold_req = 1;
				repeat (14) send_byte(noise_char(), 1);
			end
			n_texts = $urandom_range(1, 6);
			for (int t = 0; t < n_texts; t++)
				send_text(!(t == n_texts - 1 && $urandom_range(0, 5) == 0));
			settle();
			phase++;
		end
		calm = 0;

		repeat (8) @(posedge clk);
		if (tracker.errors == 0 && tracker.outstanding() == 0) begin
			$display("[case_insensitive_substring_search_unit] OK");
		end else begin
			$display("[case_insensitive_substring_search_unit] ERROR");
		end
		$finish;
	end

endmodule

FILE: filelist.f
design/cis_pkg.sv
design/cis_cell.sv
design/cis_obuf.sv
design/case_insensitive_substring_search_unit.sv
design/cis_chk.sv
dv/case_insensitive_substring_search_unit_tb.sv
